// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the histogram engine modules.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and switched off while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define HBCE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define HBCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hbce_pkg.sv =====
`default_nettype none

package hbce_pkg;

	// Field widths.
	localparam int CMD_W      = 2;
	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 13;
	localparam int HEIGHT_W   = 11;
	localparam int LEVEL_W    = 8;
	localparam int HGT_W      = 10;
	localparam int COL_W      = 12;
	localparam int TOP_W      = 11;
	localparam int OUT_CNT_W  = 32;
	localparam int COL_PROD_W = PIX_W + COL_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = WIDTH_W;

	localparam logic [CFG_IDX_W-1:0] REG_CHART_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHART_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL    = 2'd2;

	localparam logic [WIDTH_W-1:0]  CHART_WIDTH_RST  = 13'd512;
	localparam logic [HEIGHT_W-1:0] CHART_HEIGHT_RST = 11'd100;
	localparam logic [LEVEL_W-1:0]  TOP_LEVEL_RST    = 8'd255;

	// Working ranges of the registers.
	localparam int CHART_W_MIN = 2;
	localparam int CHART_W_MAX = 4096;
	localparam int CHART_H_MIN = 2;
	localparam int CHART_H_MAX = 1024;
	localparam int COL_MAX     = 4095;

	typedef enum logic [CMD_W-1:0] {
		CMD_COUNT = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic update;
		logic clear;
		logic load_prod;
		logic div_start;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t op;
		logic div_busy;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hdl/hbce_div.sv =====
`default_nettype none

`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle. The caller supplies the
// dividend as an upper part hi, already below the divisor, and a lower
// part lo of QUOT_W bits; the quotient then fits in QUOT_W bits.
module hbce_div #(
	parameter int DIVISOR_W = 32,
	parameter int QUOT_W    = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIVISOR_W-1:0] hi,
	input  wire logic [QUOT_W-1:0]    lo,
	input  wire logic [DIVISOR_W-1:0] divisor,
	output logic                      running,
	output logic [QUOT_W-1:0]         quotient
);

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [QUOT_W-1:0]    quo_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [DIVISOR_W:0] shifted;
	logic [DIVISOR_W:0] diff;
	logic               fits;

	always_comb begin
		shifted = {rem_q, quo_q[QUOT_W-1]};
		fits    = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUOT_W);
		end else if (running) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi;
			quo_q <= lo;
			dvs_q <= divisor;
		end else if (running) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[QUOT_W-2:0], fits};
		end
	end

	assign running  = cnt_q != '0;
	assign quotient = quo_q;

	`HBCE_ASSERT(a_div_start_idle, clk, arst_n, start |-> !running, "divider restarted while running")

endmodule

`default_nettype wire

// ===== hdl/hbce_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

// Sequencer: one item at a time, read, then either finish or go through
// multiply and divide for a query.
module hbce_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire hbce_pkg::ctrl_sts_t sts,
	output logic                     busy,
	output hbce_pkg::ctrl_cmd_t      cmd
);

	hbce_pkg::state_t state_q;
	hbce_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbce_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			hbce_pkg::ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = hbce_pkg::ST_EXEC;
				end
			end
			hbce_pkg::ST_EXEC: begin
				unique case (sts.op)
					hbce_pkg::CMD_COUNT: begin
						cmd.update = 1'b1;
						cmd.finish = 1'b1;
						state_d    = hbce_pkg::ST_IDLE;
					end
					hbce_pkg::CMD_CLEAR: begin
						cmd.clear  = 1'b1;
						cmd.finish = 1'b1;
						state_d    = hbce_pkg::ST_IDLE;
					end
					hbce_pkg::CMD_QUERY: begin
						cmd.load_prod = 1'b1;
						state_d       = hbce_pkg::ST_MUL;
					end
					hbce_pkg::CMD_NONE: begin
						cmd.finish = 1'b1;
						state_d    = hbce_pkg::ST_IDLE;
					end
				endcase
			end
			hbce_pkg::ST_MUL: begin
				cmd.div_start = 1'b1;
				state_d       = hbce_pkg::ST_DIV;
			end
			hbce_pkg::ST_DIV: begin
				if (!sts.div_busy) begin
					cmd.finish = 1'b1;
					state_d    = hbce_pkg::ST_IDLE;
				end
			end
		endcase
	end

	assign busy = state_q != hbce_pkg::ST_IDLE;

	`HBCE_ASSERT_NEXT(a_ctrl_accept_busy, clk, arst_n, cmd.accept, busy, "accepted word did not raise busy")
	`HBCE_ASSERT_NEXT(a_ctrl_finish_idle, clk, arst_n, cmd.finish, !busy, "controller not idle after finish")

endmodule

`default_nettype wire

// ===== hdl/hbce_dp.sv =====
`default_nettype none

`include "assert_macros.svh"

// Bin memory, peak, configuration registers, scaling arithmetic and the
// result register.
module hbce_dp #(
	parameter int NUM_BINS   = 256,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire hbce_pkg::ctrl_cmd_t                  cmd,
	output hbce_pkg::ctrl_sts_t                       sts,
	input  wire logic [hbce_pkg::CMD_W-1:0]           command,
	input  wire logic [hbce_pkg::PIX_W-1:0]           pixel_value,
	input  wire logic [hbce_pkg::PIX_W-1:0]           bin_index,
	input  wire logic                                 cfg_wen,
	input  wire logic [hbce_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [hbce_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                      done,
	output logic [hbce_pkg::OUT_CNT_W-1:0]            bin_count,
	output logic [hbce_pkg::HGT_W-1:0]                bar_height,
	output logic [hbce_pkg::COL_W-1:0]                bar_column,
	output logic [hbce_pkg::TOP_W-1:0]                bar_top_row,
	output logic                                      draw_bar,
	output logic [hbce_pkg::OUT_CNT_W-1:0]            peak_count
);

	localparam int IDX_W   = $clog2(NUM_BINS);
	localparam int HGT_W   = hbce_pkg::HGT_W;
	localparam int COL_W   = hbce_pkg::COL_W;
	localparam int TOP_W   = hbce_pkg::TOP_W;
	localparam int WW      = hbce_pkg::WIDTH_W;
	localparam int HW      = hbce_pkg::HEIGHT_W;
	localparam int LW      = hbce_pkg::LEVEL_W;
	localparam int CPW     = hbce_pkg::COL_PROD_W;
	localparam int OCW     = hbce_pkg::OUT_CNT_W;
	localparam int HPROD_W = COUNT_BITS + HGT_W;
	localparam int EXT_W   = (COUNT_BITS > OCW) ? COUNT_BITS : OCW;

	// Configuration registers, held as written and clamped where used.
	logic [WW-1:0] cw_q;
	logic [HW-1:0] ch_q;
	logic [LW-1:0] tl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= hbce_pkg::CHART_WIDTH_RST;
			ch_q <= hbce_pkg::CHART_HEIGHT_RST;
			tl_q <= hbce_pkg::TOP_LEVEL_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				hbce_pkg::REG_CHART_WIDTH:  cw_q <= cfg_data[WW-1:0];
				hbce_pkg::REG_CHART_HEIGHT: ch_q <= cfg_data[HW-1:0];
				hbce_pkg::REG_TOP_LEVEL:    tl_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [LW-1:0]    t_eff;
	logic [COL_W-1:0] wm1;
	logic [HGT_W-1:0] hm1;

	always_comb begin
		if (cw_q < WW'(hbce_pkg::CHART_W_MIN)) begin
			w_eff = WW'(hbce_pkg::CHART_W_MIN);
		end else if (cw_q > WW'(hbce_pkg::CHART_W_MAX)) begin
			w_eff = WW'(hbce_pkg::CHART_W_MAX);
		end else begin
			w_eff = cw_q;
		end
		if (ch_q < HW'(hbce_pkg::CHART_H_MIN)) begin
			h_eff = HW'(hbce_pkg::CHART_H_MIN);
		end else if (ch_q > HW'(hbce_pkg::CHART_H_MAX)) begin
			h_eff = HW'(hbce_pkg::CHART_H_MAX);
		end else begin
			h_eff = ch_q;
		end
		t_eff = (tl_q == '0) ? LW'(1) : tl_q;
		wm1   = COL_W'(w_eff - 1'b1);
		hm1   = HGT_W'(h_eff - 1'b1);
	end

	// Item capture. The bin memory is read at the same edge.
	logic [hbce_pkg::PIX_W-1:0] sel_value;
	logic [IDX_W-1:0]           rd_addr;
	logic                       sel_in_range;

	always_comb begin
		sel_value    = (hbce_pkg::cmd_t'(command) == hbce_pkg::CMD_QUERY) ?
			bin_index : pixel_value;
		rd_addr      = IDX_W'(sel_value);
		sel_in_range = int'(sel_value) < NUM_BINS;
	end

	hbce_pkg::cmd_t             op_q;
	logic [hbce_pkg::PIX_W-1:0] bin_q;
	logic [IDX_W-1:0]           addr_q;
	logic                       in_range_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= hbce_pkg::cmd_t'(command);
			bin_q      <= bin_index;
			addr_q     <= rd_addr;
			in_range_q <= sel_in_range;
		end
	end

	// Bin store. A bin whose valid bit is clear reads as zero, so reset
	// and the clear command take effect at once, with no clearing pass.
	logic [COUNT_BITS-1:0] mem_q [NUM_BINS];
	logic [NUM_BINS-1:0]   valid_q;
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  rd_vld_q;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_eff;
	logic                  do_update;

	always_comb begin
		cnt_rd    = rd_vld_q ? rd_data_q : '0;
		cnt_inc   = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;
		cnt_eff   = in_range_q ? cnt_rd : '0;
		do_update = cmd.update && in_range_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_data_q <= mem_q[rd_addr];
			rd_vld_q  <= valid_q[rd_addr];
		end
		if (do_update) begin
			mem_q[addr_q] <= cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (do_update) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	// Running peak over every bin.
	logic [COUNT_BITS-1:0] peak_q;
	logic [COUNT_BITS-1:0] peak_next;

	always_comb begin
		peak_next = peak_q;
		if (cmd.clear) begin
			peak_next = '0;
		end else if (do_update && (cnt_inc > peak_q)) begin
			peak_next = cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else begin
			peak_q <= peak_next;
		end
	end

	// Query products, one multiplier each, registered before division.
	logic [COUNT_BITS-1:0] cnt_s1;
	logic [HPROD_W-1:0]    prod_hgt_s1;
	logic [CPW-1:0]        prod_col_s1;

	always_ff @(posedge clk) begin
		if (cmd.load_prod) begin
			cnt_s1      <= cnt_eff;
			prod_hgt_s1 <= HPROD_W'(cnt_eff) * HPROD_W'(hm1);
			prod_col_s1 <= CPW'(bin_q) * CPW'(wm1);
		end
	end

	logic             hgt_run;
	logic             col_run;
	logic [HGT_W-1:0] hgt_quo;
	logic [CPW-1:0]   col_quo;

	// The count never exceeds the peak, so the upper part of the height
	// dividend is below the peak and the quotient fits the bar height.
	hbce_div #(
		.DIVISOR_W (COUNT_BITS),
		.QUOT_W    (HGT_W)
	) u_div_hgt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.hi       (prod_hgt_s1[HPROD_W-1:HGT_W]),
		.lo       (prod_hgt_s1[HGT_W-1:0]),
		.divisor  (peak_q),
		.running  (hgt_run),
		.quotient (hgt_quo)
	);

	hbce_div #(
		.DIVISOR_W (LW),
		.QUOT_W    (CPW)
	) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.hi       ('0),
		.lo       (prod_col_s1),
		.divisor  (t_eff),
		.running  (col_run),
		.quotient (col_quo)
	);

	always_comb begin
		sts.op       = op_q;
		sts.div_busy = hgt_run || col_run;
	end

	// Result word.
	logic [HGT_W-1:0] hgt_fin;
	logic [COL_W-1:0] col_fin;
	logic [EXT_W-1:0] cnt_ext;
	logic [EXT_W-1:0] peak_ext;
	logic             is_query;

	always_comb begin
		is_query = op_q == hbce_pkg::CMD_QUERY;
		hgt_fin  = (peak_q == '0) ? '0 : hgt_quo;
		col_fin  = (col_quo > CPW'(hbce_pkg::COL_MAX)) ?
			COL_W'(hbce_pkg::COL_MAX) : col_quo[COL_W-1:0];
		cnt_ext  = EXT_W'(cnt_s1);
		peak_ext = EXT_W'(peak_next);
	end

	logic                 done_q;
	logic [OCW-1:0]       bin_count_q;
	logic [HGT_W-1:0]     bar_height_q;
	logic [COL_W-1:0]     bar_column_q;
	logic [TOP_W-1:0]     bar_top_row_q;
	logic                 draw_bar_q;
	logic [OCW-1:0]       peak_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			peak_count_q <= peak_ext[OCW-1:0];
			if (is_query) begin
				bin_count_q   <= cnt_ext[OCW-1:0];
				bar_height_q  <= hgt_fin;
				bar_column_q  <= col_fin;
				bar_top_row_q <= TOP_W'(hm1) - TOP_W'(hgt_fin);
				draw_bar_q    <= (hgt_fin != '0) && (bin_q <= t_eff);
			end else begin
				bin_count_q   <= '0;
				bar_height_q  <= '0;
				bar_column_q  <= '0;
				bar_top_row_q <= '0;
				draw_bar_q    <= 1'b0;
			end
		end
	end

	assign done        = done_q;
	assign bin_count   = bin_count_q;
	assign bar_height  = bar_height_q;
	assign bar_column  = bar_column_q;
	assign bar_top_row = bar_top_row_q;
	assign draw_bar    = draw_bar_q;
	assign peak_count  = peak_count_q;

	`HBCE_ASSERT_NEXT(a_dp_done_single, clk, arst_n, done_q, !done_q, "result strobe held for two cycles")

endmodule

`default_nettype wire

// ===== hdl/histogram_bar_chart_engine.sv =====
// Histogram bar chart engine. Pulse start with a command while busy is low;
// every accepted command produces exactly one result word, presented for a
// single cycle with done high, and the receiver must take it then since it
// cannot hold results off. A count or clear command, or the unused command
// code, goes from acceptance through the EXEC state and back to IDLE. The
// bin memory is read at the accepting edge. In EXEC a count writes the
// incremented bin back and updates the peak, a clear zeroes bins and peak,
// and the result is registered. busy is low again in IDLE. A query passes
// through EXEC for the two scaling multipliers and MUL, which loads the
// dividers, then waits in DIV for the bit-serial column divider; the bar
// height divider runs alongside it and finishes first. The result is
// registered as DIV ends; done rises at the same edge at which busy falls.
// Reset and the clear command zero the bins at once through a valid bit per
// bin, so there is no clearing pass. Configuration writes are taken at any
// edge with cfg_wen high, but should only be made while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module histogram_bar_chart_engine #(
	parameter int NUM_BINS   = 256,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	// Command side.
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [hbce_pkg::CMD_W-1:0]           command,
	input  wire logic [hbce_pkg::PIX_W-1:0]           pixel_value,
	input  wire logic [hbce_pkg::PIX_W-1:0]           bin_index,

	// Configuration write port.
	input  wire logic                                 cfg_wen,
	input  wire logic [hbce_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [hbce_pkg::CFG_DATA_W-1:0]      cfg_data,

	// Result side, one word per command, strobed by done.
	output logic                                      done,
	output logic [hbce_pkg::OUT_CNT_W-1:0]            bin_count,
	output logic [hbce_pkg::HGT_W-1:0]                bar_height,
	output logic [hbce_pkg::COL_W-1:0]                bar_column,
	output logic signed [hbce_pkg::TOP_W-1:0]         bar_top_row,
	output logic                                      draw_bar,
	output logic [hbce_pkg::OUT_CNT_W-1:0]            peak_count
);

	// The controller sequences each command; the datapath owns all storage
	// and arithmetic and reports only the command in hand and whether the
	// dividers are still running.
	hbce_pkg::ctrl_cmd_t ctrl_cmd;
	hbce_pkg::ctrl_sts_t ctrl_sts;

	logic [hbce_pkg::TOP_W-1:0] top_row;

	hbce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (ctrl_sts),
		.busy   (busy),
		.cmd    (ctrl_cmd)
	);

	hbce_dp #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctrl_cmd),
		.sts         (ctrl_sts),
		.command     (command),
		.pixel_value (pixel_value),
		.bin_index   (bin_index),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.bin_count   (bin_count),
		.bar_height  (bar_height),
		.bar_column  (bar_column),
		.bar_top_row (top_row),
		.draw_bar    (draw_bar),
		.peak_count  (peak_count)
	);

	// The bar never reaches above the chart, so the first painted row is
	// never negative.
	assign bar_top_row = top_row;

	`HBCE_ASSERT(a_top_draw_height, clk, arst_n, (done && draw_bar) |-> (bar_height != '0), "bar drawn with zero height")
	`HBCE_ASSERT(a_top_row_sign, clk, arst_n, done |-> !bar_top_row[hbce_pkg::TOP_W-1], "bar top row negative")

endmodule

`default_nettype wire
